### src/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared widths and the word types passed from the front end to the back end.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Width of each coordinate field on the ports.
  localparam int FieldBits = 32;
  // Coordinates are taken from the low CoordBits bits and sign-extended.
  localparam int CoordBits = 32;
  // A difference of two coordinates needs one more bit.
  localparam int DiffBits  = CoordBits + 1;
  // Exact product of two differences.
  localparam int ProdBits  = 2 * DiffBits;
  // Rings shorter than this give outside.
  localparam int RingMin   = 3;
  // Words held between the front end and the back end.
  localparam int QueueDepth = 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;

  // One edge test: the edge counts when straddle is set and a*b < c*d.
  typedef struct packed {
    logic  straddle;
    diff_t a;
    diff_t b;
    diff_t c;
    diff_t d;
  } edge_op_t;

  // One queue word: the previous-edge and closing-edge tests and the end-of-ring control.
  typedef struct packed {
    edge_op_t prev_op;
    edge_op_t close_op;
    logic     emit;
    logic     ring_ok;
  } item_t;

endpackage

### src/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// Crossing-number point-in-polygon test
// Streams the vertices of a closed ring and reports whether the probe is inside.
// ----------------------------------------------------------------------------
// One vertex word is taken per clock cycle, back to back, while the queue is not
// full, with the probe given on the first vertex of each ring and last_vertex_i
// marking the final one. Each ring yields one result word, one bit wide, on the
// result ports: the queued word drives the cross-product multipliers into the
// product stage, and the compare and parity stage then loads the result register.
// The two-word queue between front and back end lets a held result stall the
// back end without costing input cycles until the queue fills. Rings of fewer
// than three vertices report outside.
module point_in_polygon_test_core import pip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [FieldBits-1:0] vertex_x_i,
  input  logic [FieldBits-1:0] vertex_y_i,
  input  logic [FieldBits-1:0] probe_x_i,
  input  logic [FieldBits-1:0] probe_y_i,
  input  logic                 last_vertex_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 inside_res_o
);

  item_t front_item, q_head;
  logic  accept, q_valid, q_pop;

  assign accept = push && !full;

  pip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .probe_x_i     (probe_x_i),
    .probe_y_i     (probe_y_i),
    .last_vertex_i (last_vertex_i),
    .item_o        (front_item)
  );

  pip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  pip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .item_i       (q_head),
    .pop_o        (q_pop),
    .empty_o      (empty),
    .inside_res_o (inside_res_o),
    .pop_i        (pop)
  );

  // A full queue always has a word at its head.
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_valid)
    else $error("queue reports full with no word at its head");

  // A head word that the back end does not take stays in place.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_pop && !accept) |=> (q_valid && $stable(q_head)))
    else $error("queue head changed without being taken");

  // A word is taken only when one is present.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end took a word from an empty queue");

endmodule

### src/pip_front.sv
// ----------------------------------------------------------------------------
// Point-in-polygon front end
// Holds the ring state and turns each vertex into edge tests for the back end.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [FieldBits-1:0] vertex_x_i,
  input  logic [FieldBits-1:0] vertex_y_i,
  input  logic [FieldBits-1:0] probe_x_i,
  input  logic [FieldBits-1:0] probe_y_i,
  input  logic                 last_vertex_i,
  output item_t                item_o
);

  function automatic coord_t sext(input logic [FieldBits-1:0] v);
    logic signed [FieldBits-1:0] sv;
    sv = v;
    return coord_t'(sv);
  endfunction

  // Edge with base (xi, yi) and other end (xj, yj) against probe (px, py).
  function automatic edge_op_t make_op(input coord_t xi, input coord_t yi,
                                       input coord_t xj, input coord_t yj,
                                       input coord_t px, input coord_t py);
    edge_op_t op;
    diff_t    dx;
    diff_t    dy;
    diff_t    rx;
    diff_t    ry;
    dx = diff_t'(xj) - diff_t'(xi);
    dy = diff_t'(yj) - diff_t'(yi);
    rx = diff_t'(px) - diff_t'(xi);
    ry = diff_t'(py) - diff_t'(yi);
    op.straddle = (yi > py) != (yj > py);
    if (dy > 0) begin
      op.a = rx;
      op.b = dy;
      op.c = dx;
      op.d = ry;
    end else begin
      op.a = dx;
      op.b = ry;
      op.c = rx;
      op.d = dy;
    end
    return op;
  endfunction

  localparam logic [1:0] SeenMax = 2'(RingMin);

  logic [1:0] seen_q, seen_d;
  coord_t     first_x_q, first_y_q, prev_x_q, prev_y_q, probe_x_q, probe_y_q;
  coord_t     vx, vy;
  logic       ring_start;
  edge_op_t   prev_op, close_op;

  assign vx         = sext(vertex_x_i);
  assign vy         = sext(vertex_y_i);
  assign ring_start = (seen_q == 2'd0);

  always_comb begin
    if (last_vertex_i) begin
      seen_d = 2'd0;
    end else if (ring_start) begin
      seen_d = 2'd1;
    end else if (seen_q < SeenMax) begin
      seen_d = seen_q + 2'd1;
    end else begin
      seen_d = seen_q;
    end
  end

  always_comb begin
    prev_op  = make_op(vx, vy, prev_x_q, prev_y_q, probe_x_q, probe_y_q);
    close_op = make_op(first_x_q, first_y_q, vx, vy, probe_x_q, probe_y_q);
    item_o.prev_op           = prev_op;
    item_o.prev_op.straddle  = prev_op.straddle && !ring_start;
    // The ring is long enough once this vertex is at least the third one.
    item_o.ring_ok           = (seen_q >= SeenMax - 2'd1);
    item_o.close_op          = close_op;
    item_o.close_op.straddle = close_op.straddle && last_vertex_i && item_o.ring_ok;
    item_o.emit              = last_vertex_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else if (accept_i) begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      probe_x_q <= '0;
      probe_y_q <= '0;
    end else if (accept_i) begin
      prev_x_q <= vx;
      prev_y_q <= vy;
      if (ring_start) begin
        first_x_q <= vx;
        first_y_q <= vy;
        probe_x_q <= sext(probe_x_i);
        probe_y_q <= sext(probe_y_i);
      end
    end
  end

endmodule

### src/pip_queue.sv
// ----------------------------------------------------------------------------
// Point-in-polygon word queue
// Short queue that lets the front end and the back end stall independently.
// ----------------------------------------------------------------------------
module pip_queue import pip_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(QueueDepth);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(QueueDepth - 1);

  item_t              mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### src/pip_back.sv
// ----------------------------------------------------------------------------
// Point-in-polygon back end
// Forms the cross products, compares them, keeps the parity and holds the result.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  empty_o,
  output logic  inside_res_o,
  input  logic  pop_i
);

  // Product stage.
  logic  s1_valid_q;
  prod_t s1_ab_q [2];
  prod_t s1_cd_q [2];
  logic  s1_straddle_q [2];
  logic  s1_emit_q, s1_ring_ok_q;

  // Compare stage and result register.
  logic  parity_q, parity_d;
  logic  out_valid_q, inside_q;
  logic  out_free, s2_fire, s1_load;
  logic  hit [2];

  assign out_free = !out_valid_q || pop_i;
  assign s2_fire  = s1_valid_q && (!s1_emit_q || out_free);
  assign s1_load  = !s1_valid_q || s2_fire;
  assign pop_o    = valid_i && s1_load;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hit[k] = s1_straddle_q[k] && (s1_ab_q[k] < s1_cd_q[k]);
    end
    parity_d = parity_q ^ hit[0] ^ hit[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= valid_i;
      end
      if (s2_fire) begin
        parity_q <= s1_emit_q ? 1'b0 : parity_d;
      end
      if (s2_fire && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_ab_q[0]       <= prod_t'(item_i.prev_op.a) * prod_t'(item_i.prev_op.b);
      s1_cd_q[0]       <= prod_t'(item_i.prev_op.c) * prod_t'(item_i.prev_op.d);
      s1_ab_q[1]       <= prod_t'(item_i.close_op.a) * prod_t'(item_i.close_op.b);
      s1_cd_q[1]       <= prod_t'(item_i.close_op.c) * prod_t'(item_i.close_op.d);
      s1_straddle_q[0] <= item_i.prev_op.straddle;
      s1_straddle_q[1] <= item_i.close_op.straddle;
      s1_emit_q        <= item_i.emit;
      s1_ring_ok_q     <= item_i.ring_ok;
    end
    if (s2_fire && s1_emit_q) begin
      inside_q <= s1_ring_ok_q && parity_d;
    end
  end

  assign empty_o      = !out_valid_q;
  assign inside_res_o = inside_q;

endmodule

### bench/point_in_polygon_checker.sv
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Watches the vertex and result channels of the core, predicts the inside
// bit of each ring with exact cross products and compares every result word.
// ----------------------------------------------------------------------------
module point_in_polygon_checker import pip_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic [FieldBits-1:0] vertex_x_i,
  input  logic [FieldBits-1:0] vertex_y_i,
  input  logic [FieldBits-1:0] probe_x_i,
  input  logic [FieldBits-1:0] probe_y_i,
  input  logic                 last_vertex_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 inside_res_o,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Wide enough for the exact product of two coordinate differences.
  typedef logic signed [ProdBits+1:0] wide_t;

  coord_t     ring_first_x, ring_first_y;
  coord_t     ring_prev_x, ring_prev_y;
  coord_t     probe_x, probe_y;
  bit         inside_flag;
  logic [1:0] vertex_count;
  bit         expected_inside[$];

  function automatic coord_t to_coord(logic [FieldBits-1:0] field);
    return coord_t'(field[CoordBits-1:0]);
  endfunction

  // True when the edge from base (xi, yi) to (xj, yj) straddles the probe row
  // and crosses it strictly to the right of the probe.
  function automatic bit crosses_right(coord_t xi, coord_t yi, coord_t xj, coord_t yj,
                                       coord_t px, coord_t py);
    wide_t dx, dy, ox, oy;
    if ((yi > py) == (yj > py)) return 1'b0;
    dx = wide_t'(xj) - wide_t'(xi);
    dy = wide_t'(yj) - wide_t'(yi);
    ox = wide_t'(px) - wide_t'(xi);
    oy = wide_t'(py) - wide_t'(yi);
    if (dy > 0) return (ox * dy) < (dx * oy);
    return (dx * oy) < (ox * dy);
  endfunction

  task automatic clear_ring();
    ring_first_x = '0;
    ring_first_y = '0;
    ring_prev_x  = '0;
    ring_prev_y  = '0;
    probe_x      = '0;
    probe_y      = '0;
    inside_flag  = 1'b0;
    vertex_count = '0;
  endtask

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coord_t vx, vy;
    bit     want;
    if (!rst_ni) begin
      clear_ring();
      expected_inside.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_inside.size() == 0) begin
          report_mismatch($sformatf("result word %b with no ring pending", inside_res_o));
        end else begin
          want = expected_inside.pop_front();
          if (inside_res_o !== want)
            report_mismatch($sformatf("inside_res_o is %b, expected %b", inside_res_o, want));
        end
      end
      if (push && !full) begin
        vx = to_coord(vertex_x_i);
        vy = to_coord(vertex_y_i);
        if (vertex_count == 0) begin
          probe_x      = to_coord(probe_x_i);
          probe_y      = to_coord(probe_y_i);
          ring_first_x = vx;
          ring_first_y = vy;
          inside_flag  = 1'b0;
          vertex_count = 2'd1;
        end else begin
          inside_flag ^= crosses_right(vx, vy, ring_prev_x, ring_prev_y, probe_x, probe_y);
          if (vertex_count < RingMin) vertex_count++;
        end
        ring_prev_x = vx;
        ring_prev_y = vy;
        if (last_vertex_i) begin
          // The closing edge runs from the first vertex to the last one.
          if (vertex_count >= RingMin) begin
            inside_flag ^= crosses_right(ring_first_x, ring_first_y, vx, vy,
                                         probe_x, probe_y);
            expected_inside = {expected_inside, inside_flag};
          end else begin
            expected_inside = {expected_inside, 1'b0};
          end
          clear_ring();
        end
      end
      pending_o = expected_inside.size();
    end
  end

endmodule

### bench/point_in_polygon_test_core_test.sv
// ----------------------------------------------------------------------------
// Point-in-polygon core testbench
// Streams directed and random rings into the core with random gaps and result
// stalls, fills it under a long result hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_test;
  import pip_pkg::*;

  localparam int ItemTarget  = 1750;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 8;

  localparam logic [FieldBits-1:0] CoordMax = {1'b0, {(FieldBits-1){1'b1}}};
  localparam logic [FieldBits-1:0] CoordMin = {1'b1, {(FieldBits-1){1'b0}}};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [FieldBits-1:0] vertex_x_i;
  logic [FieldBits-1:0] vertex_y_i;
  logic [FieldBits-1:0] probe_x_i;
  logic [FieldBits-1:0] probe_y_i;
  logic                 last_vertex_i;
  logic                 empty;
  logic                 pop;
  logic                 inside_res_o;

  int fail_count;
  int rings_pending;
  int words_sent;
  int cycle_count;
  int hold_count;
  int stall_left;
  bit steady;
  bit hold_req;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  point_in_polygon_test_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .probe_x_i    (probe_x_i),
    .probe_y_i    (probe_y_i),
    .last_vertex_i(last_vertex_i),
    .empty        (empty),
    .pop          (pop),
    .inside_res_o (inside_res_o)
  );

  point_in_polygon_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .probe_x_i    (probe_x_i),
    .probe_y_i    (probe_y_i),
    .last_vertex_i(last_vertex_i),
    .empty        (empty),
    .pop          (pop),
    .inside_res_o (inside_res_o),
    .fail_count_o (fail_count),
    .pending_o    (rings_pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FieldBits-1:0] coord_field(int scale);
    case (scale)
      0: return FieldBits'($urandom_range(0, 16) - 8);
      1: return FieldBits'($urandom_range(0, 2000) - 1000);
      2: return FieldBits'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          3: return '1;
          4: return CoordMax - 1;
          default: return CoordMin + 1;
        endcase
      end
    endcase
  endfunction

  task automatic push_word(input logic [FieldBits-1:0] x, y, px, py, input logic last);
    repeat (gap_cycles()) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    vertex_x_i    = x;
    vertex_y_i    = y;
    probe_x_i     = px;
    probe_y_i     = py;
    last_vertex_i = last;
    push          = 1'b1;
    do @(posedge clk_i); while (full);
    words_sent++;
  endtask

  task automatic send_ring(int n);
    logic [FieldBits-1:0] xs[$];
    logic [FieldBits-1:0] ys[$];
    logic [FieldBits-1:0] px, py;
    int                   scale;
    bit                   mixed;
    scale = $urandom_range(0, 3);
    mixed = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      xs = {xs, coord_field(mixed ? $urandom_range(0, 3) : scale)};
      ys = {ys, coord_field(mixed ? $urandom_range(0, 3) : scale)};
    end
    px = coord_field(mixed ? $urandom_range(0, 3) : scale);
    py = coord_field(mixed ? $urandom_range(0, 3) : scale);
    // Put the probe on a vertex row or column now and then to hit the ties.
    if ($urandom_range(0, 3) == 0) py = ys[$urandom_range(0, n - 1)];
    if ($urandom_range(0, 7) == 0) px = xs[$urandom_range(0, n - 1)];
    for (int i = 0; i < n; i++)
      push_word(xs[i], ys[i], (i == 0) ? px : FieldBits'($urandom),
                (i == 0) ? py : FieldBits'($urandom), i == n - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (rings_pending != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    pop        = 1'b0;
    hold_count = 0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        hold_count++;
        if (hold_count >= HoldCycles) begin
          hold_req   = 1'b0;
          hold_count = 0;
        end
      end else if (stall_left != 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) stall_left = gap_cycles();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int  ring_index;
    int  r;
    bit  was_steady;
    rst_ni        = 1'b0;
    push          = 1'b0;
    vertex_x_i    = '0;
    vertex_y_i    = '0;
    probe_x_i     = '0;
    probe_y_i     = '0;
    last_vertex_i = 1'b0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    words_sent    = 0;
    ring_index    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Ring of one vertex, then a ring of two: both are outside.
    push_word(CoordMax, CoordMin, CoordMin, CoordMax, 1'b1);
    push_word(CoordMin, CoordMax, CoordMax, CoordMin, 1'b0);
    push_word('1, '0, CoordMax, CoordMax, 1'b1);
    // Square around the probe, then the same square with the probe outside.
    push_word(-10, -10, 0, 0, 1'b0);
    push_word(10, -10, 5, 5, 1'b0);
    push_word(10, 10, CoordMin, CoordMin, 1'b0);
    push_word(-10, 10, CoordMax, CoordMax, 1'b1);
    push_word(-10, -10, 20, 0, 1'b0);
    push_word(10, -10, 0, 0, 1'b0);
    push_word(10, 10, 0, 0, 1'b0);
    push_word(-10, 10, 0, 0, 1'b1);
    // Triangle spanning the whole coordinate range.
    push_word(CoordMin, CoordMin, 0, 0, 1'b0);
    push_word(CoordMax, CoordMin, '1, '1, 1'b0);
    push_word(0, CoordMax, CoordMin, CoordMax, 1'b1);
    // Probe on a corner, with a horizontal edge through it.
    push_word(0, 0, 0, 0, 1'b0);
    push_word(10, 0, 0, 0, 1'b0);
    push_word(0, 10, 0, 0, 1'b1);
    // Probe on the boundary, on an edge at the extreme x of the range.
    push_word(CoordMax, CoordMax, CoordMax, 0, 1'b0);
    push_word(CoordMin, CoordMax, 0, 0, 1'b0);
    push_word(CoordMax, CoordMin, 0, 0, 1'b1);
    wait_drained();

    while (words_sent < ItemTarget) begin
      ring_index++;
      if (ring_index % 37 == 0) steady = !steady;
      if (ring_index % 50 == 25) wait_drained();
      // Hold the result side off while one-vertex rings keep coming, so the
      // core fills and stalls its input.
      if (ring_index == 60 || ring_index == 220) begin
        was_steady = steady;
        steady     = 1'b1;
        hold_req   = 1'b1;
        repeat (16) send_ring(1);
        steady = was_steady;
      end
      r = $urandom_range(0, 99);
      if (r < 8) send_ring(1);
      else if (r < 15) send_ring(2);
      else if (r < 85) send_ring($urandom_range(3, 6));
      else send_ring($urandom_range(7, 20));
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
